FILE: rtl/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg
// Types and constants shared by the route point interpolator.
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int unsigned MaxPoints     = 1024;
  localparam int unsigned CoordFracBits = 24;
  localparam int unsigned AddrW         = $clog2(MaxPoints);
  localparam int unsigned CountW        = AddrW + 1;
  localparam int unsigned CoordW        = 25;
  localparam int unsigned DistW         = 32;
  localparam int unsigned NumW          = DistW + 1;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;
  localparam logic [1:0] CmdNop    = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [CoordW-1:0]       point_x;
    logic [CoordW-1:0]       point_y;
    logic signed [DistW-1:0] point_dist;
    logic signed [DistW-1:0] query_dist;
  } rpi_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [CoordW-1:0]       out_x;
    logic [CoordW-1:0]       out_y;
    logic signed [DistW-1:0] out_dist;
  } rpi_out_t;

endpackage

FILE: rtl/route_point_interpolator_top.sv
// ----------------------------------------------------------------------------
// route_point_interpolator_top
// Route point table with linear scan and fixed-point interpolation.
// ----------------------------------------------------------------------------
// Query: the scan reads one entry per cycle from the point memories; a match
//   at entry N >= 1 is followed by a 24-step restoring divide and a 24-step
//   shift-add multiply for both axes. A miss at the first entry, or no match,
//   ends the scan with an out-of-range result.
// Throughput: one item at a time; next input taken the cycle after the
//   result transfers.
// Reset: entry count and control cleared; point memories are not cleared,
//   only entries below the count are ever used.
module route_point_interpolator_top
  import rpi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rpi_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rpi_out_t out_data_o
);

  typedef enum logic [7:0] {
    SIdle = 8'b0000_0001,
    SScan = 8'b0000_0010,  // address issued, data next cycle
    SCmp  = 8'b0000_0100,
    SRdP  = 8'b0000_1000,  // previous entry read returns
    SDiv  = 8'b0001_0000,
    SMul  = 8'b0010_0000,
    SFin  = 8'b0100_0000,
    SOut  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // point memories, one read port, one write port
  logic [CoordW-1:0] x_mem [MaxPoints];
  logic [CoordW-1:0] y_mem [MaxPoints];
  logic [DistW-1:0]  d_mem [MaxPoints];
  logic [CoordW-1:0] x_rd_q, y_rd_q;
  logic [DistW-1:0]  d_rd_q;
  logic [AddrW-1:0]  rd_addr;
  logic              we;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] idx_q;
  rpi_in_t           item_q;
  rpi_out_t          res_q;

  // captured endpoints
  logic [CoordW-1:0] nx_q, ny_q;
  logic signed [DistW-1:0] nd_q;

  // divider / multiplier
  logic [NumW-1:0]          rem_q, den_q;
  logic [CoordFracBits-1:0] frac_q;
  logic [5:0]               step_q;
  logic [CoordW+CoordFracBits-1:0] accx_q, accy_q;
  logic [CoordW-1:0]        magx_q, magy_q, px_q, py_q;
  logic                     negx_q, negy_q;

  logic in_take, out_take;
  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = res_q;

  assign we = in_take && (in_data_i.cmd == CmdAppend) && (count_q < CountW'(MaxPoints));

  // scan keeps one read ahead of the compare; on a match fetch the entry before
  always_comb begin
    rd_addr = idx_q[AddrW-1:0];
    if (state_q == SCmp) begin
      rd_addr = (state_d == SRdP) ? AddrW'(idx_q - CountW'(1))
                                  : AddrW'(idx_q + CountW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      x_mem[count_q[AddrW-1:0]] <= in_data_i.point_x;
      y_mem[count_q[AddrW-1:0]] <= in_data_i.point_y;
      d_mem[count_q[AddrW-1:0]] <= in_data_i.point_dist;
    end
    x_rd_q <= x_mem[rd_addr];
    y_rd_q <= y_mem[rd_addr];
    d_rd_q <= d_mem[rd_addr];
  end

  // trial subtract for the restoring divide
  logic [NumW:0] rem2, trial;
  assign rem2  = {rem_q, 1'b0};
  assign trial = rem2 - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (in_take) state_d = (in_data_i.cmd == CmdQuery) ? SScan : SOut;
      SScan: state_d = SCmp;
      SCmp: begin
        if (idx_q >= count_q) state_d = SOut;
        else if ($signed(item_q.query_dist) < $signed(d_rd_q))
          state_d = (idx_q == '0) ? SOut : SRdP;
        else state_d = SCmp;
      end
      SRdP: state_d = SDiv;
      SDiv: if (step_q == 6'(CoordFracBits - 1)) state_d = SMul;
      SMul: if (step_q == 6'(CoordFracBits - 1)) state_d = SFin;
      SFin: state_d = SOut;
      SOut: if (out_take) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        idx_q <= '0;
        if (in_data_i.cmd == CmdClear) count_q <= '0;
        else if (we) count_q <= count_q + CountW'(1);
      end
      if (state_q == SScan) idx_q <= idx_q;
      if (state_q == SCmp && state_d == SCmp) idx_q <= idx_q + CountW'(1);
      if (state_q == SRdP || (state_q == SDiv && state_d == SMul)) step_q <= '0;
      else if (state_q == SDiv || state_q == SMul) step_q <= step_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
      res_q.status   <= (in_data_i.cmd == CmdAppend && !we) ? StFull : StOk;
      res_q.out_x    <= '0;
      res_q.out_y    <= '0;
      res_q.out_dist <= '0;
    end
    case (state_q)
      SCmp: begin
        nx_q <= x_rd_q; ny_q <= y_rd_q; nd_q <= d_rd_q;
        if (state_d == SOut) begin
          res_q.status   <= StRange;
          res_q.out_dist <= '1;
        end
      end
      SRdP: begin
        rem_q <= NumW'($signed(item_q.query_dist)) - NumW'($signed(d_rd_q));
        den_q <= NumW'($signed(nd_q)) - NumW'($signed(d_rd_q));
        px_q <= x_rd_q; py_q <= y_rd_q;
        negx_q <= nx_q < x_rd_q; negy_q <= ny_q < y_rd_q;
        magx_q <= (nx_q < x_rd_q) ? x_rd_q - nx_q : nx_q - x_rd_q;
        magy_q <= (ny_q < y_rd_q) ? y_rd_q - ny_q : ny_q - y_rd_q;
        accx_q <= '0; accy_q <= '0;
      end
      SDiv: begin
        if (!trial[NumW]) begin
          rem_q <= trial[NumW-1:0];
          frac_q <= {frac_q[CoordFracBits-2:0], 1'b1};
        end else begin
          rem_q <= rem2[NumW-1:0];
          frac_q <= {frac_q[CoordFracBits-2:0], 1'b0};
        end
      end
      SMul: begin
        accx_q <= {accx_q[CoordW+CoordFracBits-2:0], 1'b0}
                + (frac_q[CoordFracBits-1] ? (CoordW+CoordFracBits)'(magx_q) : '0);
        accy_q <= {accy_q[CoordW+CoordFracBits-2:0], 1'b0}
                + (frac_q[CoordFracBits-1] ? (CoordW+CoordFracBits)'(magy_q) : '0);
        frac_q <= {frac_q[CoordFracBits-2:0], 1'b0};
      end
      SFin: begin
        res_q.status   <= StOk;
        res_q.out_dist <= item_q.query_dist;
        res_q.out_x <= negx_q ? px_q - accx_q[CoordW+CoordFracBits-1:CoordFracBits]
                              : px_q + accx_q[CoordW+CoordFracBits-1:CoordFracBits];
        res_q.out_y <= negy_q ? py_q - accy_q[CoordW+CoordFracBits-1:CoordFracBits]
                              : py_q + accy_q[CoordW+CoordFracBits-1:CoordFracBits];
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/rpi_checker.sv
// ----------------------------------------------------------------------------
// rpi_checker
// Port-level checks for the route point interpolator.
// ----------------------------------------------------------------------------
module rpi_checker
  import rpi_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input rpi_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rpi_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  a_invalid_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StRange |-> out_data_o.out_dist == '1
      && out_data_o.out_x == '0)
    else $error("bad invalid query result");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StFull |-> out_data_o.out_dist == '0)
    else $error("bad full result");

endmodule

bind route_point_interpolator_top rpi_checker u_rpi_checker (.*);
